[hdl/tchc_pkg.sv]
// shared types, constants and helpers for the texture container header check
// used by tchc_parser, tchc_result_fifo and the top level; no dependencies
`default_nettype none

package tchc_pkg;

    localparam int MAX_LEVELS   = 16;
    localparam int HDR_BYTES    = 80;
    localparam int ENTRY_BYTES  = 24;
    localparam int MAGIC_BYTES  = 12;
    localparam int POS_W        = 10;
    localparam int PHASE_W      = $clog2(ENTRY_BYTES);
    localparam int ENTRY_NUM_W  = 5;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
        8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h32,
        8'h30, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic KIND_LEVEL   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SHORT_HDR = 4'd1;
    localparam logic [3:0] ERR_MAGIC     = 4'd2;
    localparam logic [3:0] ERR_WIDTH     = 4'd3;
    localparam logic [3:0] ERR_NO_LEVELS = 4'd4;
    localparam logic [3:0] ERR_TOO_MANY  = 4'd5;
    localparam logic [3:0] ERR_SHORT_IDX = 4'd6;
    localparam logic [3:0] ERR_LEVEL     = 4'd7;
    localparam logic [3:0] ERR_DFD       = 4'd8;
    localparam logic [3:0] ERR_KVD       = 4'd9;
    localparam logic [3:0] ERR_SGD       = 4'd10;

    typedef struct packed {
        logic        first_byte;
        logic [31:0] file_size;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  level_number;
        logic [63:0] level_offset;
        logic [63:0] level_length;
        logic [63:0] level_raw_length;
        logic        header_ok;
        logic [3:0]  error_code;
        logic [31:0] pixel_width;
        logic [31:0] pixel_height;
        logic [31:0] pixel_depth;
        logic [31:0] mip_levels;
        logic [31:0] supercompression_mode;
    } result_t;

    // up to two results per input transaction, r0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic range_bad(input logic [63:0] off, input logic [63:0] len,
                                       input logic [31:0] sz);
        logic [63:0] sz64;
        sz64 = {32'd0, sz};
        return (off > sz64) || (len > sz64 - off);
    endfunction

    function automatic result_t make_summary(input logic [3:0] code,
                                             input logic [31:0] w, input logic [31:0] h,
                                             input logic [31:0] d, input logic [31:0] lv,
                                             input logic [31:0] sc);
        result_t r;
        r = '0;
        r.result_kind          = KIND_SUMMARY;
        r.header_ok            = (code == ERR_NONE);
        r.error_code           = code;
        r.pixel_width          = w;
        r.pixel_height         = h;
        r.pixel_depth          = d;
        r.mip_levels           = lv;
        r.supercompression_mode = sc;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/tchc_parser.sv]
// byte-serial header parser: position counter, field shifter, header words
// and level index checks; depends on tchc_pkg
`default_nettype none

module tchc_parser
    import tchc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     consume,
    input  wire in_item_t in_item,
    output push_t         push
);

    logic [POS_W-1:0]       pos_reg, pos_next, pos_e;
    logic                   finished_reg, finished_next;
    logic [31:0]            size_reg, size_next;
    logic [63:0]            fs_reg, fs_next, fs_e, fs_shift;
    logic [31:0]            hw_reg [9];
    logic [31:0]            hw_next [9];
    logic [31:0]            hw_e [9];
    logic [63:0]            sgd_off_reg, sgd_off_next, sgd_off_e;
    logic [63:0]            sgd_len_reg, sgd_len_next, sgd_len_e;
    logic [63:0]            ent_off_reg, ent_off_next, ent_off_e;
    logic [63:0]            ent_len_reg, ent_len_next, ent_len_e;
    logic [ENTRY_NUM_W-1:0] ent_num_reg, ent_num_next, ent_num_e, ent_num_inc;
    logic [PHASE_W-1:0]     phase_reg, phase_next, phase_e;
    logic                   entry_bad_reg;
    logic [3:0]             trailer_code_reg, trailer_code_next;
    logic                   restart, active;
    logic [7:0]             b;
    logic [31:0]            index_end;

    assign restart  = consume && in_item.first_byte;
    assign active   = consume && (in_item.first_byte || !finished_reg);
    assign b        = in_item.data_byte;

    // state as seen by this byte: a restart clears everything first
    assign pos_e     = restart ? '0 : pos_reg;
    assign fs_e      = restart ? '0 : fs_reg;
    assign sgd_off_e = restart ? '0 : sgd_off_reg;
    assign sgd_len_e = restart ? '0 : sgd_len_reg;
    assign ent_off_e = restart ? '0 : ent_off_reg;
    assign ent_len_e = restart ? '0 : ent_len_reg;
    assign ent_num_e = restart ? '0 : ent_num_reg;
    assign phase_e   = restart ? '0 : phase_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            hw_e[i] = restart ? 32'd0 : hw_reg[i];
        end
    end

    assign fs_shift    = {b, fs_e[63:8]};
    assign ent_num_inc = ent_num_e + 1'b1;
    assign index_end   = 32'(HDR_BYTES)
                       + 32'(ENTRY_BYTES) * 32'(hw_e[3][$clog2(MAX_LEVELS+1)-1:0]);

    always_comb begin
        pos_next      = pos_e;
        finished_next = restart ? 1'b0 : finished_reg;
        size_next     = restart ? in_item.file_size : size_reg;
        fs_next       = fs_e;
        hw_next       = hw_e;
        sgd_off_next  = sgd_off_e;
        sgd_len_next  = sgd_len_e;
        ent_off_next  = ent_off_e;
        ent_len_next  = ent_len_e;
        ent_num_next  = ent_num_e;
        phase_next    = phase_e;
        push          = '0;

        if (active) begin
            if (restart && (in_item.file_size < 32'(HDR_BYTES))) begin
                push.count    = 2'd1;
                push.r0       = make_summary(ERR_SHORT_HDR, '0, '0, '0, '0, '0);
                finished_next = 1'b1;
            end else begin
                pos_next = pos_e + 1'b1;
                if (pos_e < POS_W'(MAGIC_BYTES)) begin
                    if (b != MAGIC[pos_e[3:0]]) begin
                        push.count    = 2'd1;
                        push.r0       = make_summary(ERR_MAGIC, hw_e[0], hw_e[1], hw_e[2],
                                                     hw_e[3], hw_e[4]);
                        finished_next = 1'b1;
                    end
                end else begin
                    fs_next = fs_shift;
                    if (pos_e < POS_W'(64)) begin
                        // last byte of each 32-bit header field that is kept
                        case (pos_e)
                            10'd23:  hw_next[0] = fs_shift[63:32];
                            10'd27:  hw_next[1] = fs_shift[63:32];
                            10'd31:  hw_next[2] = fs_shift[63:32];
                            10'd43:  hw_next[3] = fs_shift[63:32];
                            10'd47:  hw_next[4] = fs_shift[63:32];
                            10'd51:  hw_next[5] = fs_shift[63:32];
                            10'd55:  hw_next[6] = fs_shift[63:32];
                            10'd59:  hw_next[7] = fs_shift[63:32];
                            10'd63:  hw_next[8] = fs_shift[63:32];
                            default: ;
                        endcase
                    end else if (pos_e < POS_W'(HDR_BYTES)) begin
                        if (pos_e == 10'd71) sgd_off_next = fs_shift;
                        if (pos_e == POS_W'(HDR_BYTES - 1)) begin
                            sgd_len_next = fs_shift;
                            if (hw_e[0] == 32'd0) begin
                                push.count = 2'd1;
                                push.r0    = make_summary(ERR_WIDTH, hw_e[0], hw_e[1],
                                                          hw_e[2], hw_e[3], hw_e[4]);
                            end else if (hw_e[3] == 32'd0) begin
                                push.count = 2'd1;
                                push.r0    = make_summary(ERR_NO_LEVELS, hw_e[0], hw_e[1],
                                                          hw_e[2], hw_e[3], hw_e[4]);
                            end else if (hw_e[3] > 32'(MAX_LEVELS)) begin
                                push.count = 2'd1;
                                push.r0    = make_summary(ERR_TOO_MANY, hw_e[0], hw_e[1],
                                                          hw_e[2], hw_e[3], hw_e[4]);
                            end else if (index_end > size_reg) begin
                                push.count = 2'd1;
                                push.r0    = make_summary(ERR_SHORT_IDX, hw_e[0], hw_e[1],
                                                          hw_e[2], hw_e[3], hw_e[4]);
                            end
                            if (push.count != 2'd0) finished_next = 1'b1;
                        end
                    end else begin
                        phase_next = (phase_e == PHASE_W'(ENTRY_BYTES - 1)) ? '0
                                   : phase_e + 1'b1;
                        if (phase_e == PHASE_W'(7)) begin
                            ent_off_next = fs_shift;
                        end else if (phase_e == PHASE_W'(15)) begin
                            ent_len_next = fs_shift;
                        end else if (phase_e == PHASE_W'(ENTRY_BYTES - 1)) begin
                            if (entry_bad_reg) begin
                                push.count    = 2'd1;
                                push.r0       = make_summary(ERR_LEVEL, hw_e[0], hw_e[1],
                                                             hw_e[2], hw_e[3], hw_e[4]);
                                finished_next = 1'b1;
                            end else begin
                                push.count                = 2'd1;
                                push.r0.result_kind       = KIND_LEVEL;
                                push.r0.level_number      = ent_num_e[3:0];
                                push.r0.level_offset      = ent_off_e;
                                push.r0.level_length      = ent_len_e;
                                push.r0.level_raw_length  = fs_shift;
                                ent_num_next              = ent_num_inc;
                                if ({27'd0, ent_num_inc} >= hw_e[3]) begin
                                    push.count    = 2'd2;
                                    push.r1       = make_summary(trailer_code_reg, hw_e[0],
                                                                 hw_e[1], hw_e[2], hw_e[3],
                                                                 hw_e[4]);
                                    finished_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // dfd, kvd and sgd checks settle long before the first entry completes
    always_comb begin
        trailer_code_next = ERR_NONE;
        if (hw_reg[6] != 32'd0 && range_bad({32'd0, hw_reg[5]}, {32'd0, hw_reg[6]}, size_reg))
        begin
            trailer_code_next = ERR_DFD;
        end else if (hw_reg[8] != 32'd0
                     && range_bad({32'd0, hw_reg[7]}, {32'd0, hw_reg[8]}, size_reg)) begin
            trailer_code_next = ERR_KVD;
        end else if (sgd_len_reg != 64'd0 && range_bad(sgd_off_reg, sgd_len_reg, size_reg))
        begin
            trailer_code_next = ERR_SGD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            finished_reg <= 1'b1;
            ent_num_reg  <= '0;
            phase_reg    <= '0;
        end else begin
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
            ent_num_reg  <= ent_num_next;
            phase_reg    <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg         <= size_next;
        fs_reg           <= fs_next;
        hw_reg           <= hw_next;
        sgd_off_reg      <= sgd_off_next;
        sgd_len_reg      <= sgd_len_next;
        ent_off_reg      <= ent_off_next;
        ent_len_reg      <= ent_len_next;
        entry_bad_reg    <= range_bad(ent_off_reg, ent_len_reg, size_reg);
        trailer_code_reg <= trailer_code_next;
    end

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (push.r0.result_kind == KIND_LEVEL
                                && push.r1.result_kind == KIND_SUMMARY))
        else $error("two results must be a level result then a summary");

    a_summary_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd1 && push.r0.result_kind == KIND_SUMMARY) |=> finished_reg)
        else $error("summary did not end the file");

    a_level_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0 && push.r0.result_kind == KIND_LEVEL)
        |-> (pos_e >= POS_W'(HDR_BYTES) && !entry_bad_reg))
        else $error("level result outside the level index");

endmodule

`default_nettype wire

[hdl/tchc_result_fifo.sv]
// four-entry result queue taking up to two results per cycle, one out per cycle while out_ready is high
// depends on tchc_pkg
`default_nettype none

module tchc_result_fifo
    import tchc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_head  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a worst-case pair, judged on the registered count only
    assign room      = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) mem[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2) mem[PTR_W'(wr_ptr_reg + 1'b1)] <= push.r1;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> (32'(count_reg) + 32'(push.count) <= FIFO_DEPTH))
        else $error("result queue overflow");

    a_pop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on a pop");

endmodule

`default_nettype wire

[hdl/texture_container_header_check_unit.sv]
// top level of the texture container header check: input register, parser, result queue
// depends on tchc_pkg, tchc_parser and tchc_result_fifo
//
// Feed a container file one byte per transaction with s_tuser set on its first
// byte, which also carries the total file size. The unit accepts one byte per
// clock cycle while the result queue has room; the byte is held in an input
// register and parsed from there, and its results are registered in the queue. Each
// completed level index entry yields a level result (tuser 0), and the file
// ends with one summary (tuser 1) carrying the error code; the last entry gives
// both, level result first. Results wait in a four-entry queue, and input is
// held off only while that queue has fewer than two free slots. After a
// summary, bytes are ignored until the next first byte; a first byte in the
// middle of a file abandons it without a summary.
`default_nettype none

module texture_container_header_check_unit
    import tchc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // data_byte[7:0], file_size[39:8]
    input  wire logic         s_tuser,   // first_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // level_number[3:0], level_offset[67:4], level_length[131:68],
    // level_raw_length[195:132], header_ok[196], error_code[200:197],
    // pixel_width[232:201], pixel_height[264:233], pixel_depth[296:265],
    // mip_levels[328:297], supercompression_mode[360:329], zero pad
    output logic [367:0]      m_tdata,
    output logic              m_tuser    // result_kind
);

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg, in_item_next;
    logic     room, consume;
    push_t    push;
    result_t  head;

    assign consume       = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || room;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);
    assign in_item_next  = (s_tvalid && s_tready)
                         ? in_item_t'{first_byte: s_tuser, file_size: s_tdata[39:8],
                                      data_byte: s_tdata[7:0]}
                         : in_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    tchc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (consume),
        .in_item (in_item_reg),
        .push    (push)
    );

    tchc_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_head  (head)
    );

    assign m_tuser = head.result_kind;
    assign m_tdata = {7'd0, head.supercompression_mode, head.mip_levels, head.pixel_depth,
                      head.pixel_height, head.pixel_width, head.error_code, head.header_ok,
                      head.level_raw_length, head.level_length, head.level_offset,
                      head.level_number};

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held input transaction was lost");

endmodule

`default_nettype wire
